// ===== sv/utc_adj_pkg.sv =====
package utc_adj_pkg;

   // Field widths
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned YEAR_W   = 14;
   localparam int unsigned OFFSET_W = 6;
   localparam int unsigned HOUR_OUT_W = 7;

   // Calendar constants
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [YEAR_W-1:0]  SENTINEL_YEAR_MAX = 14'd2000;
   localparam logic signed [HOUR_OUT_W-1:0] HOURS_PER_DAY = 7'sd24;

   // Divisibility by 25 over 14 bits: multiply by the inverse of 25 mod 2^14,
   // the value is a multiple of 25 exactly when the low product is <= 16383/25.
   localparam logic [YEAR_W-1:0] INV25_MOD = 14'd7209;
   localparam logic [YEAR_W-1:0] DIV25_LIMIT = YEAR_W'(((1 << YEAR_W) - 1) / 25);

   // One input item
   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
   } req_item_type;

   // One result item
   typedef struct packed {
      logic signed [HOUR_OUT_W-1:0] hour;
      logic [DAY_W-1:0]             day;
      logic [MONTH_W-1:0]           month;
      logic [YEAR_W-1:0]            year;
   } rsp_item_type;

   // Days in a month (1..12); February follows the leap flag
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

// ===== sv/utc_adj_leap.sv =====
// Gregorian leap-year flag: divisible by 4 and not by 100, or by 400
module utc_adj_leap (
   input  logic [utc_adj_pkg::YEAR_W-1:0] year,
   output logic                           leap
);
   import utc_adj_pkg::*;

   logic [YEAR_W-1:0] inv_prod;
   logic              div4;
   logic              div16;
   logic              div25;

   // Divisibility by 25 through the modular inverse (low product only)
   assign inv_prod = YEAR_W'(year * INV25_MOD);
   assign div25    = (inv_prod <= DIV25_LIMIT);
   assign div4     = (year[1:0] == 2'b00);
   assign div16    = (year[3:0] == 4'b0000);

   // 100 = 4*25, 400 = 16*25
   assign leap = (div4 && !div25) || (div16 && div25);

endmodule

// ===== sv/utc_adj_calc.sv =====
// Hour shift with day, month and year carry for one item
module utc_adj_calc (
   input  utc_adj_pkg::req_item_type                  item,
   input  logic signed [utc_adj_pkg::OFFSET_W-1:0]    offset,
   output utc_adj_pkg::rsp_item_type                  result
);
   import utc_adj_pkg::*;

   logic                          leap;
   logic                          time_zero;
   logic                          no_date;
   logic                          month_ok;
   logic signed [HOUR_OUT_W-1:0]  hour_sum;
   logic signed [HOUR_OUT_W-1:0]  hour_up;
   logic signed [HOUR_OUT_W-1:0]  hour_wrap;
   logic                          day_dec;
   logic                          day_inc;
   logic signed [HOUR_OUT_W-1:0]  day_adj;
   logic [MONTH_W-1:0]            month_prev;
   logic [MONTH_W-1:0]            month_next;
   logic [DAY_W-1:0]              cur_len;
   logic [DAY_W-1:0]              prev_len;

   utc_adj_leap u_leap (
      .year (item.year),
      .leap (leap)
   );

   // Item classification
   assign time_zero = (item.hour == '0) && (item.minute == '0) && (item.second == '0);
   assign no_date   = (item.month == '0) && (item.day == '0) &&
                      (item.year <= SENTINEL_YEAR_MAX);
   assign month_ok  = item.month inside {[MONTH_JAN:MONTH_DEC]};

   // Hour sum and single wrap into a day
   assign hour_sum  = $signed({2'b00, item.hour}) + HOUR_OUT_W'(offset);
   assign day_dec   = (hour_sum <= 0);
   assign hour_up   = day_dec ? hour_sum + HOURS_PER_DAY : hour_sum;
   assign day_inc   = (hour_up >= HOURS_PER_DAY);
   assign hour_wrap = day_inc ? hour_up - HOURS_PER_DAY : hour_up;
   assign day_adj   = $signed({2'b00, item.day}) + HOUR_OUT_W'({1'b0, day_inc})
                      - HOUR_OUT_W'({1'b0, day_dec});

   // Neighbor months and their lengths
   assign month_prev = (item.month == MONTH_JAN) ? MONTH_DEC : item.month - 4'd1;
   assign month_next = (item.month == MONTH_DEC) ? MONTH_JAN : item.month + 4'd1;
   assign cur_len    = month_len(item.month, leap);
   assign prev_len   = month_len(month_prev, leap);

   // Result selection
   always_comb begin
      result.hour  = $signed({2'b00, item.hour});
      result.day   = item.day;
      result.month = item.month;
      result.year  = item.year;
      if (!time_zero) begin
         if (no_date) begin
            result.hour = hour_sum;
         end else begin
            result.hour = hour_wrap;
            if (month_ok) begin
               if (day_adj <= 0) begin
                  result.day   = prev_len;
                  result.month = month_prev;
                  if (item.month == MONTH_JAN) begin
                     result.year = item.year - 14'd1;
                  end
               end else if (day_adj > $signed({2'b00, cur_len})) begin
                  result.day   = 5'd1;
                  result.month = month_next;
                  if (item.month == MONTH_DEC) begin
                     result.year = item.year + 14'd1;
                  end
               end else begin
                  result.day = day_adj[DAY_W-1:0];
               end
            end
         end
      end
   end

endmodule

// ===== sv/utc_adj_top.sv =====
// Each accepted item passes the input register and then the result register, which drives rsp_strobe.
// Throughput: 1 item per cycle; busy is tied low, so the input is never stalled.
// Results cannot be stalled by the receiver: rsp_strobe is high for one cycle per item.
// Reset (synchronous, active high) clears the pipeline valids and sets the offset to 0.
module utc_offset_date_time_adjust (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   output logic                                           busy,
   input  logic [utc_adj_pkg::HOUR_W-1:0]                 req_hour_in,
   input  logic [utc_adj_pkg::MINUTE_W-1:0]               req_minute_in,
   input  logic [utc_adj_pkg::SECOND_W-1:0]               req_second_in,
   input  logic [utc_adj_pkg::DAY_W-1:0]                  req_day_in,
   input  logic [utc_adj_pkg::MONTH_W-1:0]                req_month_in,
   input  logic [utc_adj_pkg::YEAR_W-1:0]                 req_year_in,
   output logic                                           rsp_strobe,
   output logic signed [utc_adj_pkg::HOUR_OUT_W-1:0]      rsp_hour_out,
   output logic [utc_adj_pkg::DAY_W-1:0]                  rsp_day_out,
   output logic [utc_adj_pkg::MONTH_W-1:0]                rsp_month_out,
   output logic [utc_adj_pkg::YEAR_W-1:0]                 rsp_year_out,
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic signed [utc_adj_pkg::OFFSET_W-1:0]        csr_data
);
   import utc_adj_pkg::*;

   logic                         accept;
   logic                         stage_valid_ff;
   logic                         stage_valid_in;
   req_item_type                 stage_item_ff;
   req_item_type                 stage_item_in;
   logic                         rsp_valid_ff;
   rsp_item_type                 rsp_item_ff;
   rsp_item_type                 rsp_item_in;
   logic signed [OFFSET_W-1:0]   offset_ff;
   logic signed [OFFSET_W-1:0]   offset_in;

   // Handshakes: never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Offset register
   assign offset_in = (csr_valid && csr_ready) ? csr_data : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   // Input register
   assign stage_valid_in = accept;
   always_comb begin
      stage_item_in        = stage_item_ff;
      if (accept) begin
         stage_item_in.hour   = req_hour_in;
         stage_item_in.minute = req_minute_in;
         stage_item_in.second = req_second_in;
         stage_item_in.day    = req_day_in;
         stage_item_in.month  = req_month_in;
         stage_item_in.year   = req_year_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
   end

   // Date/time adjust
   utc_adj_calc u_calc (
      .item   (stage_item_ff),
      .offset (offset_ff),
      .result (rsp_item_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_hour_out  = rsp_item_ff.hour;
   assign rsp_day_out   = rsp_item_ff.day;
   assign rsp_month_out = rsp_item_ff.month;
   assign rsp_year_out  = rsp_item_ff.year;

`ifndef NO_ASSERTIONS
   // Every accepted item yields a strobe once it has passed the input and result registers
   a_item_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted item produced no result");

   // A strobe only follows a valid input stage
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(stage_valid_ff))
      else $error("result strobe without a staged item");

   // A valid month stays a valid month through the carry logic
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && stage_item_ff.month >= MONTH_JAN && stage_item_ff.month <= MONTH_DEC)
      |=> (rsp_month_out >= MONTH_JAN && rsp_month_out <= MONTH_DEC))
      else $error("month carry left the range 1..12");
`endif

endmodule
